/* src/mwsq_pkg.sv */
// Shared types, constants and arithmetic helpers for the wave-vector unit.
package mwsq_pkg;

   localparam int GRID_MAX_DEFAULT = 256;
   localparam int SIZE_W   = 9;    // packed grid size field
   localparam int IDX_W    = 8;    // grid index
   localparam int N_W      = 11;   // shifted index, signed
   localparam int G_W      = 32;   // Q16.16 matrix entry
   localparam int P_W      = G_W + N_W;
   localparam int OUT_W    = 48;
   localparam int MAG_W    = 32;
   localparam int SQ_W     = 2 * MAG_W;
   localparam int ADDR_W   = 5;
   localparam int DATA_W   = 32;
   localparam int GRID_REG_W = 27;

   localparam logic [GRID_REG_W-1:0] GRID_RESET = 27'd262657;
   localparam logic [G_W-1:0]        DIAG_RESET = 32'd411775;
   localparam logic [OUT_W-1:0]      OUT_MAX    = '1;

   typedef enum logic [2:0] {
      REG_GRID_SIZES = 3'd0,
      REG_ROW0_COL0  = 3'd1,
      REG_ROW1_COL0  = 3'd2,
      REG_ROW1_COL1  = 3'd3,
      REG_ROW2_COL0  = 3'd4,
      REG_ROW2_COL1  = 3'd5,
      REG_ROW2_COL2  = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [SIZE_W-1:0] size_a;
      logic [SIZE_W-1:0] size_b;
      logic [SIZE_W-1:0] size_c;
      logic [G_W-1:0]    g00;
      logic [G_W-1:0]    g10;
      logic [G_W-1:0]    g11;
      logic [G_W-1:0]    g20;
      logic [G_W-1:0]    g21;
      logic [G_W-1:0]    g22;
   } cfg_type;

   // signed matrix entry times signed shifted index, exact
   function automatic logic signed [P_W-1:0] mul_gn(input logic [G_W-1:0] g,
                                                    input logic signed [N_W-1:0] n);
      logic signed [P_W-1:0] ge;
      logic signed [P_W-1:0] ne;
      ge = P_W'($signed(g));
      ne = P_W'(n);
      return ge * ne;
   endfunction

   function automatic logic [OUT_W-1:0] min3(input logic [OUT_W-1:0] x,
                                             input logic [OUT_W-1:0] y,
                                             input logic [OUT_W-1:0] z);
      logic [OUT_W-1:0] t;
      t = (y < x) ? y : x;
      return (z < t) ? z : t;
   endfunction

endpackage

/* src/mwsq_csr.sv */
// APB register file holding grid sizes and the reciprocal matrix.
module mwsq_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [mwsq_pkg::ADDR_W-1:0]     paddr,
   input  logic [mwsq_pkg::DATA_W-1:0]     pwdata,
   output logic [mwsq_pkg::DATA_W-1:0]     prdata,
   output logic                            pready,
   output mwsq_pkg::cfg_type               cfg
);

   logic [mwsq_pkg::GRID_REG_W-1:0] grid_ff, grid_in;
   logic [mwsq_pkg::G_W-1:0] g00_ff, g10_ff, g11_ff, g20_ff, g21_ff, g22_ff;
   logic [mwsq_pkg::G_W-1:0] g00_in, g10_in, g11_in, g20_in, g21_in, g22_in;
   logic                     wr_en;
   mwsq_pkg::reg_index_type  sel;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;
   assign sel    = mwsq_pkg::reg_index_type'(paddr[4:2]);

   always_comb begin
      grid_in = grid_ff;
      g00_in  = g00_ff;
      g10_in  = g10_ff;
      g11_in  = g11_ff;
      g20_in  = g20_ff;
      g21_in  = g21_ff;
      g22_in  = g22_ff;
      prdata  = '0;
      case (sel)
         mwsq_pkg::REG_GRID_SIZES: begin
            prdata = mwsq_pkg::DATA_W'(grid_ff);
            if (wr_en) grid_in = pwdata[mwsq_pkg::GRID_REG_W-1:0];
         end
         mwsq_pkg::REG_ROW0_COL0: begin
            prdata = g00_ff;
            if (wr_en) g00_in = pwdata;
         end
         mwsq_pkg::REG_ROW1_COL0: begin
            prdata = g10_ff;
            if (wr_en) g10_in = pwdata;
         end
         mwsq_pkg::REG_ROW1_COL1: begin
            prdata = g11_ff;
            if (wr_en) g11_in = pwdata;
         end
         mwsq_pkg::REG_ROW2_COL0: begin
            prdata = g20_ff;
            if (wr_en) g20_in = pwdata;
         end
         mwsq_pkg::REG_ROW2_COL1: begin
            prdata = g21_ff;
            if (wr_en) g21_in = pwdata;
         end
         mwsq_pkg::REG_ROW2_COL2: begin
            prdata = g22_ff;
            if (wr_en) g22_in = pwdata;
         end
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_ff <= mwsq_pkg::GRID_RESET;
         g00_ff  <= mwsq_pkg::DIAG_RESET;
         g10_ff  <= '0;
         g11_ff  <= mwsq_pkg::DIAG_RESET;
         g20_ff  <= '0;
         g21_ff  <= '0;
         g22_ff  <= mwsq_pkg::DIAG_RESET;
      end else begin
         grid_ff <= grid_in;
         g00_ff  <= g00_in;
         g10_ff  <= g10_in;
         g11_ff  <= g11_in;
         g20_ff  <= g20_in;
         g21_ff  <= g21_in;
         g22_ff  <= g22_in;
      end
   end

   assign cfg.size_a = grid_ff[8:0];
   assign cfg.size_b = grid_ff[17:9];
   assign cfg.size_c = grid_ff[26:18];
   assign cfg.g00    = g00_ff;
   assign cfg.g10    = g10_ff;
   assign cfg.g11    = g11_ff;
   assign cfg.g20    = g20_ff;
   assign cfg.g21    = g21_ff;
   assign cfg.g22    = g22_ff;

endmodule

/* src/min_image_wavevector_sq_unit.sv */
// Top level: minimum-image squared reciprocal wave-vector, 9-stage pipeline.
//
//   channel   direction  handshake            payload
//   req_*     in         req_valid/req_stall  index_a, index_b, index_c (8b each)
//   rsp_*     out        rsp_valid/rsp_stall  wave_sq_min (48b, Q32.16)
//   csr (APB) in         psel/penable/pready  grid sizes, six Q16.16 matrix entries
//
// One beat enters per cycle unless a stalled output holds the pipeline.
// Stages: shifted indices, products, row sums, magnitudes, squares, image sums,
// then a three-level minimum tree over the 27 images.
// A stalled output freezes the whole pipeline; req_stall follows it.
// Reset clears the valid bits and loads the register defaults.
module min_image_wavevector_sq_unit #(
   parameter int GRID_MAX = mwsq_pkg::GRID_MAX_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [mwsq_pkg::IDX_W-1:0]      req_index_a,
   input  logic [mwsq_pkg::IDX_W-1:0]      req_index_b,
   input  logic [mwsq_pkg::IDX_W-1:0]      req_index_c,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [mwsq_pkg::OUT_W-1:0]      rsp_wave_sq_min,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [mwsq_pkg::ADDR_W-1:0]     paddr,
   input  logic [mwsq_pkg::DATA_W-1:0]     pwdata,
   output logic [mwsq_pkg::DATA_W-1:0]     prdata,
   output logic                            pready
);

   localparam int NSTAGE = 9;
   localparam int N_W = mwsq_pkg::N_W;
   localparam int P_W = mwsq_pkg::P_W;
   localparam int MAG_W = mwsq_pkg::MAG_W;
   localparam int SQ_W = mwsq_pkg::SQ_W;
   localparam int OUT_W = mwsq_pkg::OUT_W;
   localparam int SIZE_W = mwsq_pkg::SIZE_W;
   localparam int Q1_W = P_W + 1;
   localparam int Q2_W = P_W + 2;
   localparam int SUM_W = SQ_W + 2;
   localparam logic [SIZE_W-1:0] SIZE_CAP = SIZE_W'(GRID_MAX);

   mwsq_pkg::cfg_type cfg;

   mwsq_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .psel   (psel),
      .penable(penable),
      .pwrite (pwrite),
      .paddr  (paddr),
      .pwdata (pwdata),
      .prdata (prdata),
      .pready (pready),
      .cfg    (cfg)
   );

   logic adv;
   logic [NSTAGE-1:0] valid_ff, valid_in;

   assign adv       = ~(valid_ff[NSTAGE-1] & rsp_stall);
   assign req_stall = ~adv;
   assign rsp_valid = valid_ff[NSTAGE-1];
   assign valid_in  = {valid_ff[NSTAGE-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   // stage 1: shifted indices, order +1, 0, -1
   logic [SIZE_W-1:0] na, nb, nc;
   logic signed [N_W-1:0] n0_ff[3], n1_ff[3], n2_ff[3];
   logic signed [N_W-1:0] n0_in[3], n1_in[3], n2_in[3];

   assign na = (cfg.size_a > SIZE_CAP) ? SIZE_CAP : cfg.size_a;
   assign nb = (cfg.size_b > SIZE_CAP) ? SIZE_CAP : cfg.size_b;
   assign nc = (cfg.size_c > SIZE_CAP) ? SIZE_CAP : cfg.size_c;

   always_comb begin
      n0_in[0] = $signed(N_W'(req_index_a)) + $signed(N_W'(na));
      n0_in[1] = $signed(N_W'(req_index_a));
      n0_in[2] = $signed(N_W'(req_index_a)) - $signed(N_W'(na));
      n1_in[0] = $signed(N_W'(req_index_b)) + $signed(N_W'(nb));
      n1_in[1] = $signed(N_W'(req_index_b));
      n1_in[2] = $signed(N_W'(req_index_b)) - $signed(N_W'(nb));
      n2_in[0] = $signed(N_W'(req_index_c)) + $signed(N_W'(nc));
      n2_in[1] = $signed(N_W'(req_index_c));
      n2_in[2] = $signed(N_W'(req_index_c)) - $signed(N_W'(nc));
   end

   // stage 2: the 18 matrix-by-index products
   logic signed [P_W-1:0] p00_ff[3], p10_ff[3], p11_ff[3], p20_ff[3], p21_ff[3], p22_ff[3];
   logic signed [P_W-1:0] p00_in[3], p10_in[3], p11_in[3], p20_in[3], p21_in[3], p22_in[3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         p00_in[i] = mwsq_pkg::mul_gn(cfg.g00, n0_ff[i]);
         p10_in[i] = mwsq_pkg::mul_gn(cfg.g10, n0_ff[i]);
         p11_in[i] = mwsq_pkg::mul_gn(cfg.g11, n1_ff[i]);
         p20_in[i] = mwsq_pkg::mul_gn(cfg.g20, n0_ff[i]);
         p21_in[i] = mwsq_pkg::mul_gn(cfg.g21, n1_ff[i]);
         p22_in[i] = mwsq_pkg::mul_gn(cfg.g22, n2_ff[i]);
      end
   end

   // stage 3: components; q1 per (i,j), q2 per (i,j,k)
   logic signed [P_W-1:0]  q0_ff[3], q0_in[3];
   logic signed [Q1_W-1:0] q1_ff[9], q1_in[9];
   logic signed [Q2_W-1:0] q2_ff[27], q2_in[27];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         q0_in[i] = p00_ff[i];
         for (int j = 0; j < 3; j++) begin
            q1_in[i*3+j] = Q1_W'(p10_ff[i]) + Q1_W'(p11_ff[j]);
            for (int k = 0; k < 3; k++) begin
               q2_in[i*9+j*3+k] = Q2_W'(p20_ff[i]) + Q2_W'(p21_ff[j]) + Q2_W'(p22_ff[k]);
            end
         end
      end
   end

   // stage 4: magnitudes, flag any component reaching 2^32
   logic [MAG_W-1:0] m0_ff[3], m1_ff[9], m2_ff[27];
   logic [MAG_W-1:0] m0_in[3], m1_in[9], m2_in[27];
   logic [2:0]  o0_ff, o0_in;
   logic [8:0]  o1_ff, o1_in;
   logic [26:0] o2_ff, o2_in;

   always_comb begin
      logic [P_W-1:0]  a0;
      logic [Q1_W-1:0] a1;
      logic [Q2_W-1:0] a2;
      for (int i = 0; i < 3; i++) begin
         a0 = q0_ff[i][P_W-1] ? P_W'(-q0_ff[i]) : P_W'(q0_ff[i]);
         m0_in[i] = a0[MAG_W-1:0];
         o0_in[i] = |a0[P_W-1:MAG_W];
      end
      for (int i = 0; i < 9; i++) begin
         a1 = q1_ff[i][Q1_W-1] ? Q1_W'(-q1_ff[i]) : Q1_W'(q1_ff[i]);
         m1_in[i] = a1[MAG_W-1:0];
         o1_in[i] = |a1[Q1_W-1:MAG_W];
      end
      for (int i = 0; i < 27; i++) begin
         a2 = q2_ff[i][Q2_W-1] ? Q2_W'(-q2_ff[i]) : Q2_W'(q2_ff[i]);
         m2_in[i] = a2[MAG_W-1:0];
         o2_in[i] = |a2[Q2_W-1:MAG_W];
      end
   end

   // stage 5: squares
   logic [SQ_W-1:0] s0_ff[3], s1_ff[9], s2_ff[27];
   logic [SQ_W-1:0] s0_in[3], s1_in[9], s2_in[27];
   logic [2:0]  f0_ff;
   logic [8:0]  f1_ff;
   logic [26:0] f2_ff;

   always_comb begin
      for (int i = 0; i < 3; i++)  s0_in[i] = SQ_W'(m0_ff[i]) * SQ_W'(m0_ff[i]);
      for (int i = 0; i < 9; i++)  s1_in[i] = SQ_W'(m1_ff[i]) * SQ_W'(m1_ff[i]);
      for (int i = 0; i < 27; i++) s2_in[i] = SQ_W'(m2_ff[i]) * SQ_W'(m2_ff[i]);
   end

   // stage 6: per-image sum, truncate to Q32.16, saturate
   logic [OUT_W-1:0] img_ff[27], img_in[27];

   always_comb begin
      logic [SUM_W-1:0] sum;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            for (int k = 0; k < 3; k++) begin
               sum = SUM_W'(s0_ff[i]) + SUM_W'(s1_ff[i*3+j]) + SUM_W'(s2_ff[i*9+j*3+k]);
               if (f0_ff[i] | f1_ff[i*3+j] | f2_ff[i*9+j*3+k] | (|sum[SUM_W-1:OUT_W+16]))
                  img_in[i*9+j*3+k] = mwsq_pkg::OUT_MAX;
               else
                  img_in[i*9+j*3+k] = sum[OUT_W+15:16];
            end
         end
      end
   end

   // stages 7-9: minimum tree, 27 -> 9 -> 3 -> 1
   logic [OUT_W-1:0] min9_ff[9], min9_in[9];
   logic [OUT_W-1:0] min3_ff[3], min3_in[3];
   logic [OUT_W-1:0] best_ff, best_in;

   always_comb begin
      for (int i = 0; i < 9; i++)
         min9_in[i] = mwsq_pkg::min3(img_ff[3*i], img_ff[3*i+1], img_ff[3*i+2]);
      for (int i = 0; i < 3; i++)
         min3_in[i] = mwsq_pkg::min3(min9_ff[3*i], min9_ff[3*i+1], min9_ff[3*i+2]);
      best_in = mwsq_pkg::min3(min3_ff[0], min3_ff[1], min3_ff[2]);
   end

   assign rsp_wave_sq_min = best_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         n0_ff   <= n0_in;
         n1_ff   <= n1_in;
         n2_ff   <= n2_in;
         p00_ff  <= p00_in;
         p10_ff  <= p10_in;
         p11_ff  <= p11_in;
         p20_ff  <= p20_in;
         p21_ff  <= p21_in;
         p22_ff  <= p22_in;
         q0_ff   <= q0_in;
         q1_ff   <= q1_in;
         q2_ff   <= q2_in;
         m0_ff   <= m0_in;
         m1_ff   <= m1_in;
         m2_ff   <= m2_in;
         o0_ff   <= o0_in;
         o1_ff   <= o1_in;
         o2_ff   <= o2_in;
         s0_ff   <= s0_in;
         s1_ff   <= s1_in;
         s2_ff   <= s2_in;
         f0_ff   <= o0_ff;
         f1_ff   <= o1_ff;
         f2_ff   <= o2_ff;
         img_ff  <= img_in;
         min9_ff <= min9_in;
         min3_ff <= min3_in;
         best_ff <= best_in;
      end
   end

endmodule

/* tb/tb.sv */
// Self-checking testbench for the minimum-image squared wave-vector unit.
`timescale 1ns / 1ps

module tb;

   localparam int CLK_HALF   = 2;
   localparam int RESET_CYC  = 12;
   localparam int PIPE_DEPTH = 9;
   localparam int LONG_HOLD  = 300;
   localparam longint CYCLE_LIMIT = 600000;
   localparam int ADDR_W     = mwsq_pkg::ADDR_W;
   localparam int DATA_W     = mwsq_pkg::DATA_W;
   localparam int IDX_W      = mwsq_pkg::IDX_W;
   localparam int OUT_W      = mwsq_pkg::OUT_W;
   localparam int G_W        = mwsq_pkg::G_W;
   localparam int SIZE_W     = mwsq_pkg::SIZE_W;
   localparam int GRID_REG_W = mwsq_pkg::GRID_REG_W;
   localparam logic [ADDR_W-1:0] UNMAPPED_ADDR = ADDR_W'(7 * 4);
   localparam logic [OUT_W-1:0] SAT_VALUE = '1;

   typedef struct {
      logic [IDX_W-1:0] a;
      logic [IDX_W-1:0] b;
      logic [IDX_W-1:0] c;
   } grid_index_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [IDX_W-1:0] req_index_a = '0, req_index_b = '0, req_index_c = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [OUT_W-1:0] rsp_wave_sq_min;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [ADDR_W-1:0] paddr = '0;
   logic [DATA_W-1:0] pwdata = '0;
   logic [DATA_W-1:0] prdata;
   logic pready;

   min_image_wavevector_sq_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_index_a(req_index_a), .req_index_b(req_index_b), .req_index_c(req_index_c),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_wave_sq_min(rsp_wave_sq_min),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // local copy of the register file
   logic [GRID_REG_W-1:0] grid_sizes_q = mwsq_pkg::GRID_RESET;
   logic [G_W-1:0] recip_q [1:6] = '{mwsq_pkg::DIAG_RESET, 32'd0, mwsq_pkg::DIAG_RESET,
                                     32'd0, 32'd0, mwsq_pkg::DIAG_RESET};

   grid_index_type pending_beats[$];
   logic [OUT_W-1:0] expected_norms[$];
   int  mismatches = 0;
   int  beats_out = 0;
   bit  beat_taken = 0;
   bit  burst_mode = 0;
   int  send_gap = 0;
   int  hold_left = 0;
   bit  long_hold_done = 0;
   longint cycles = 0;

   initial begin
      forever #CLK_HALF clock = ~clock;
   end

   function automatic logic [OUT_W-1:0] image_norm(longint q0, longint q1, longint q2);
      longint q[3];
      logic [63:0] m, sq, hi, lo, total;
      q[0] = q0; q[1] = q1; q[2] = q2;
      hi = 0;
      lo = 0;
      for (int r = 0; r < 3; r++) begin
         m = (q[r] < 0) ? 64'(-q[r]) : 64'(q[r]);
         if (m >= 64'h1_0000_0000) return SAT_VALUE;
         sq = m * m;
         hi += sq >> 16;
         lo += {48'd0, sq[15:0]};
      end
      total = hi + (lo >> 16);
      return (total > {16'd0, SAT_VALUE}) ? SAT_VALUE : total[OUT_W-1:0];
   endfunction

   function automatic longint clamp_size(logic [SIZE_W-1:0] s);
      return (s > mwsq_pkg::GRID_MAX_DEFAULT) ? longint'(mwsq_pkg::GRID_MAX_DEFAULT)
                                              : longint'(s);
   endfunction

   function automatic logic [OUT_W-1:0] min_image_norm(grid_index_type x);
      longint na, nb, nc, n0, n1, n2, g00, g10, g11, g20, g21, g22;
      logic [OUT_W-1:0] best, v;
      na = clamp_size(grid_sizes_q[8:0]);
      nb = clamp_size(grid_sizes_q[17:9]);
      nc = clamp_size(grid_sizes_q[26:18]);
      g00 = longint'($signed(recip_q[mwsq_pkg::REG_ROW0_COL0]));
      g10 = longint'($signed(recip_q[mwsq_pkg::REG_ROW1_COL0]));
      g11 = longint'($signed(recip_q[mwsq_pkg::REG_ROW1_COL1]));
      g20 = longint'($signed(recip_q[mwsq_pkg::REG_ROW2_COL0]));
      g21 = longint'($signed(recip_q[mwsq_pkg::REG_ROW2_COL1]));
      g22 = longint'($signed(recip_q[mwsq_pkg::REG_ROW2_COL2]));
      best = SAT_VALUE;
      for (int i = -1; i <= 1; i++)
         for (int j = -1; j <= 1; j++)
            for (int k = -1; k <= 1; k++) begin
               n0 = longint'(x.a) + i * na;
               n1 = longint'(x.b) + j * nb;
               n2 = longint'(x.c) + k * nc;
               v = image_norm(g00 * n0, g10 * n0 + g11 * n1, g20 * n0 + g21 * n1 + g22 * n2);
               if (v < best) best = v;
            end
      return best;
   endfunction

   task automatic report_mismatch(string what, logic [OUT_W-1:0] got, logic [OUT_W-1:0] want);
      $display("MISMATCH %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
      mismatches++;
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (burst_mode || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // input driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || beat_taken) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_beats.size() > 0) begin
            grid_index_type nx;
            nx = pending_beats.pop_front();
            req_index_a <= nx.a;
            req_index_b <= nx.b;
            req_index_c <= nx.c;
            req_valid <= 1'b1;
            send_gap <= pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall: one long hold once traffic is flowing, else random gaps (none in burst mode)
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (!long_hold_done && beats_out >= 300) begin
         long_hold_done <= 1;
         hold_left <= LONG_HOLD;
         rsp_stall <= 1'b1;
      end else if (burst_mode) begin
         rsp_stall <= 1'b0;
      end else begin
         int r;
         r = $urandom_range(0, 99);
         if (r < 60) rsp_stall <= 1'b0;
         else if (r < 95) hold_left <= $urandom_range(0, 2);
         else hold_left <= $urandom_range(10, 40);
         if (r >= 60) rsp_stall <= 1'b1;
      end
   end

   // accept tracking, prediction and result checking
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else if (!reset) begin
         beat_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            grid_index_type x;
            x.a = req_index_a;
            x.b = req_index_b;
            x.c = req_index_c;
            expected_norms.push_back(min_image_norm(x));
         end
         if (rsp_valid && !rsp_stall) begin
            beats_out <= beats_out + 1;
            if (expected_norms.size() == 0)
               report_mismatch("unexpected beat", rsp_wave_sq_min, '0);
            else begin
               logic [OUT_W-1:0] want;
               want = expected_norms.pop_front();
               if (rsp_wave_sq_min !== want)
                  report_mismatch("wave_sq_min", rsp_wave_sq_min, want);
            end
         end
      end
   end

   task automatic csr_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
      @(negedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= addr;
      pwdata <= data;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (addr == ADDR_W'(mwsq_pkg::REG_GRID_SIZES * 4)) grid_sizes_q = data[GRID_REG_W-1:0];
      else if (addr != UNMAPPED_ADDR) recip_q[addr >> 2] = data;
   endtask

   task automatic load_config(logic [GRID_REG_W-1:0] sizes, logic [G_W-1:0] g[1:6]);
      mwsq_pkg::reg_index_type ri;
      csr_write(ADDR_W'(mwsq_pkg::REG_GRID_SIZES * 4), DATA_W'(sizes));
      for (int r = 1; r <= 6; r++) begin
         ri = mwsq_pkg::reg_index_type'(r);
         csr_write(ADDR_W'(ri * 4), g[r]);
      end
   endtask

   task automatic queue_beat(int a, int b, int c);
      grid_index_type x;
      x.a = IDX_W'(a);
      x.b = IDX_W'(b);
      x.c = IDX_W'(c);
      pending_beats.push_back(x);
   endtask

   task automatic drain();
      wait (pending_beats.size() == 0 && !req_valid && expected_norms.size() == 0);
      repeat (PIPE_DEPTH + 3) @(posedge clock);
   endtask

   function automatic logic [G_W-1:0] rand_entry();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) return G_W'($signed($urandom_range(0, 2 * 600000)) - 600000);
      if (r < 8) return G_W'($signed($urandom_range(0, 2 * 60000)) - 60000);
      return $urandom();
   endfunction

   function automatic logic [SIZE_W-1:0] rand_size();
      int r;
      r = $urandom_range(0, 9);
      if (r < 7) return SIZE_W'($urandom_range(1, 256));
      if (r < 8) return '0;
      return SIZE_W'($urandom_range(257, 511));
   endfunction

   initial begin
      logic [G_W-1:0] g[1:6];
      repeat (RESET_CYC) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset defaults: sizes of one, so most indices lie beyond their size
      queue_beat(0, 0, 0);
      queue_beat(255, 255, 255);
      queue_beat(1, 0, 0);
      queue_beat(0, 255, 1);
      queue_beat(170, 85, 255);
      drain();

      // zero sizes and the largest positive entries: saturating images
      g = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
      load_config('0, g);
      queue_beat(0, 0, 0);
      queue_beat(1, 0, 0);
      queue_beat(255, 255, 255);
      queue_beat(0, 0, 1);
      drain();

      // sizes above the limit and the most negative entries
      g = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
      load_config('1, g);
      csr_write(UNMAPPED_ADDR, 32'hFFFF_FFFF);
      queue_beat(0, 0, 0);
      queue_beat(255, 255, 255);
      queue_beat(128, 128, 128);
      drain();

      // realistic cell, index at and beyond the grid size
      g = '{32'd411775, 32'hFFFF_8000, 32'd300000, 32'd12345, 32'hFFFE_0000, 32'd500000};
      load_config({9'd16, 9'd255, 9'd2}, g);
      queue_beat(2, 255, 16);
      queue_beat(3, 254, 200);
      queue_beat(1, 127, 8);
      queue_beat(0, 128, 9);
      queue_beat(255, 0, 15);
      drain();

      // random configurations with random index streams
      for (int phase = 0; phase < 8; phase++) begin
         for (int r = 1; r <= 6; r++) g[r] = rand_entry();
         load_config({rand_size(), rand_size(), rand_size()}, g);
         burst_mode = (phase == 3);
         for (int n = 0; n < 106; n++)
            queue_beat($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
         drain();
      end
      burst_mode = 0;

      drain();
      if (mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
